FILE: hw/rtl/rte_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helper functions for the rtc register to epoch converter
// no dependencies; used by rte_decode, rte_days, rte_epoch, the top level and the bench

package rte_pkg;

    // field masks of the raw register bytes
    localparam logic [7:0] OSC_STOP_BIT = 8'h80;
    localparam logic [7:0] MASK_7       = 8'h7F;
    localparam logic [7:0] MASK_6       = 8'h3F;
    localparam logic [7:0] MASK_5       = 8'h1F;
    localparam logic [7:0] MASK_3       = 8'h07;

    // field limits in binary
    localparam logic [6:0] SEC_MAX   = 7'd59;
    localparam logic [6:0] MIN_MAX   = 7'd59;
    localparam logic [6:0] HOUR_MAX  = 7'd23;
    localparam logic [6:0] DAY_MAX   = 7'd31;
    localparam logic [6:0] MONTH_MAX = 7'd12;
    localparam logic [6:0] YEAR_MAX  = 7'd99;
    localparam logic [2:0] WDAY_MAX  = 3'd6;
    localparam logic [3:0] MONTH_FEB = 4'd2;

    // time constants
    localparam logic [15:0] DAYS_TO_2000  = 16'd10957;  // 1970-01-01 to 2000-01-01
    localparam logic [15:0] DAYS_PER_YEAR = 16'd365;
    localparam logic [16:0] SEC_PER_DAY   = 17'd86400;
    localparam logic [16:0] SEC_PER_HOUR  = 17'd3600;
    localparam logic [16:0] SEC_PER_MIN   = 17'd60;
    localparam logic [11:0] YEAR_BASE     = 12'd2000;

    // raw register set as taken from the input channel
    typedef struct packed {
        logic [7:0] seconds_code;
        logic [7:0] minutes_code;
        logic [7:0] hours_code;
        logic [7:0] days_code;
        logic [7:0] weekday_code;
        logic [7:0] months_code;
        logic [7:0] years_code;
    } t_raw;

    // decoded calendar fields, all zero when the check failed
    typedef struct packed {
        logic       ok;
        logic [6:0] year_off;
        logic [3:0] month;
        logic [4:0] day;
        logic [2:0] weekday;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_dec;

    // day count and second of day
    typedef struct packed {
        t_dec        cal;
        logic [15:0] days;
        logic [16:0] sod;
    } t_day;

    // day count scaled to seconds
    typedef struct packed {
        t_dec        cal;
        logic [31:0] day_secs;
        logic [16:0] sod;
    } t_prod;

    // final result item
    typedef struct packed {
        logic        valid_res;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  weekday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [31:0] utc_epoch;
    } t_res;

    // two bcd digits to binary
    function automatic logic [6:0] bcd_val(input logic [7:0] b);
        logic [6:0] tens;
        tens = {3'b000, b[7:4]};
        return (tens << 3) + (tens << 1) + {3'b000, b[3:0]};
    endfunction

    // both digits decimal and the value within its limit
    function automatic logic bcd_ok(input logic [7:0] b, input logic [6:0] limit);
        return (b[3:0] <= 4'd9) && (b[7:4] <= 4'd9) && (bcd_val(b) <= limit);
    endfunction

    // days in a month, month assumed 1..12
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // days before the first of a month in a common year
    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

FILE: hw/rtl/rte_in_if.sv
`timescale 1ns / 1ps
// input channel: valid/ready handshake carrying one rtc register set
// no dependencies

interface rte_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] seconds_code;
    logic [7:0] minutes_code;
    logic [7:0] hours_code;
    logic [7:0] days_code;
    logic [7:0] weekday_code;
    logic [7:0] months_code;
    logic [7:0] years_code;

    modport source (
        output valid, seconds_code, minutes_code, hours_code, days_code,
               weekday_code, months_code, years_code,
        input  ready
    );

    modport sink (
        input  valid, seconds_code, minutes_code, hours_code, days_code,
               weekday_code, months_code, years_code,
        output ready
    );
endinterface

FILE: hw/rtl/rte_out_if.sv
`timescale 1ns / 1ps
// output channel: valid/ready handshake carrying calendar fields and epoch seconds
// no dependencies

interface rte_out_if;
    logic        valid;
    logic        ready;
    logic        valid_res;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [31:0] utc_epoch;

    modport source (
        output valid, valid_res, year, month, day, weekday, hour, minute, second,
               utc_epoch,
        input  ready
    );

    modport sink (
        input  valid, valid_res, year, month, day, weekday, hour, minute, second,
               utc_epoch,
        output ready
    );
endinterface

FILE: hw/rtl/rte_decode.sv
`timescale 1ns / 1ps
// stage 1: masks, bcd decode and range, month-length and stop-flag checks
// depends on rte_pkg

module rte_decode (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_osc_check,
    input  logic            i_valid,
    output logic            o_ready,
    input  rte_pkg::t_raw   i_raw,
    output logic            o_valid,
    input  logic            i_ready,
    output rte_pkg::t_dec   o_dec
);

    logic          r_valid;
    rte_pkg::t_dec r_dec;
    rte_pkg::t_dec n_dec;

    logic [7:0] sec_b, min_b, hour_b, day_b, mon_b, year_b;
    logic [2:0] wday;
    logic [6:0] day_v, mon_v;
    logic [6:0] hour_v, min_v, sec_v, year_v;
    logic       leap;
    logic       ok;

    // stage advances when empty or when downstream takes its item
    assign o_ready = !r_valid || i_ready;

    // field decode and validity checks
    always_comb begin
        sec_b  = i_raw.seconds_code & rte_pkg::MASK_7;
        min_b  = i_raw.minutes_code & rte_pkg::MASK_7;
        hour_b = i_raw.hours_code   & rte_pkg::MASK_6;
        day_b  = i_raw.days_code    & rte_pkg::MASK_6;
        mon_b  = i_raw.months_code  & rte_pkg::MASK_5;
        year_b = i_raw.years_code;
        wday   = i_raw.weekday_code[2:0];
        day_v  = rte_pkg::bcd_val(day_b);
        mon_v  = rte_pkg::bcd_val(mon_b);
        hour_v = rte_pkg::bcd_val(hour_b);
        min_v  = rte_pkg::bcd_val(min_b);
        sec_v  = rte_pkg::bcd_val(sec_b);
        year_v = rte_pkg::bcd_val(year_b);
        // within 2000..2099 every fourth year is leap, 2000 included;
        // even tens digit needs units 0, 4 or 8, odd tens digit needs units 2 or 6
        leap   = year_b[4] ? (year_b[3:0] == 4'd2 || year_b[3:0] == 4'd6)
                           : (year_b[3:0] == 4'd0 || year_b[3:0] == 4'd4
                              || year_b[3:0] == 4'd8);
        ok = !(i_osc_check && ((i_raw.seconds_code & rte_pkg::OSC_STOP_BIT) != 8'h00))
             && rte_pkg::bcd_ok(sec_b,  rte_pkg::SEC_MAX)
             && rte_pkg::bcd_ok(min_b,  rte_pkg::MIN_MAX)
             && rte_pkg::bcd_ok(hour_b, rte_pkg::HOUR_MAX)
             && rte_pkg::bcd_ok(day_b,  rte_pkg::DAY_MAX)
             && rte_pkg::bcd_ok(mon_b,  rte_pkg::MONTH_MAX)
             && rte_pkg::bcd_ok(year_b, rte_pkg::YEAR_MAX)
             && (mon_v != 7'd0) && (day_v != 7'd0)
             && (day_v <= {2'b00, rte_pkg::month_len(mon_v[3:0], leap)})
             && (wday <= rte_pkg::WDAY_MAX);

        n_dec = '0;
        if (ok) begin
            n_dec.ok       = 1'b1;
            n_dec.year_off = year_v;
            n_dec.month    = mon_v[3:0];
            n_dec.day      = day_v[4:0];
            n_dec.weekday  = wday;
            n_dec.hour     = hour_v[4:0];
            n_dec.minute   = min_v[5:0];
            n_dec.second   = sec_v[5:0];
        end
    end

    // stage valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_dec <= n_dec;
        end
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;

endmodule

FILE: hw/rtl/rte_days.sv
`timescale 1ns / 1ps
// stage 2: day count since 1970 and second of day
// depends on rte_pkg

module rte_days (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  rte_pkg::t_dec   i_dec,
    output logic            o_valid,
    input  logic            i_ready,
    output rte_pkg::t_day   o_day
);

    logic          r_valid;
    rte_pkg::t_day r_day;
    rte_pkg::t_day n_day;

    logic [15:0] yoff;
    logic [15:0] leap_days;
    logic        leap_adj;

    assign o_ready = !r_valid || i_ready;

    // days = base + whole years + leap days before this year + day of year
    always_comb begin
        yoff      = {9'b0, i_dec.year_off};
        leap_days = (yoff + 16'd3) >> 2;
        leap_adj  = (i_dec.year_off[1:0] == 2'b00) && (i_dec.month > rte_pkg::MONTH_FEB);
        n_day.cal  = i_dec;
        n_day.days = rte_pkg::DAYS_TO_2000 + yoff * rte_pkg::DAYS_PER_YEAR + leap_days
                     + {7'b0, rte_pkg::days_before(i_dec.month)} + {15'b0, leap_adj}
                     + {11'b0, i_dec.day} - 16'd1;
        n_day.sod  = {12'b0, i_dec.hour} * rte_pkg::SEC_PER_HOUR
                     + {11'b0, i_dec.minute} * rte_pkg::SEC_PER_MIN
                     + {11'b0, i_dec.second};
    end

    // stage valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_day <= n_day;
        end
    end

    assign o_valid = r_valid;
    assign o_day   = r_day;

endmodule

FILE: hw/rtl/rte_epoch.sv
`timescale 1ns / 1ps
// stages 3 and 4: day count times 86400, then add second of day into the output register
// depends on rte_pkg

module rte_epoch (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  rte_pkg::t_day   i_day,
    output logic            o_valid,
    input  logic            i_ready,
    output rte_pkg::t_res   o_res
);

    logic           r_valid_mul;
    logic           r_valid_out;
    logic           ready_out;
    rte_pkg::t_prod r_prod;
    rte_pkg::t_prod n_prod;
    rte_pkg::t_res  r_res;
    rte_pkg::t_res  n_res;
    logic [32:0]    prod_full;

    assign ready_out = !r_valid_out || i_ready;
    assign o_ready   = !r_valid_mul || ready_out;

    // multiply stage
    always_comb begin
        prod_full       = {17'b0, i_day.days} * {16'b0, rte_pkg::SEC_PER_DAY};
        n_prod.cal      = i_day.cal;
        n_prod.day_secs = prod_full[31:0];
        n_prod.sod      = i_day.sod;
    end

    // final add and zeroing of rejected items
    always_comb begin
        n_res.valid_res = r_prod.cal.ok;
        n_res.year      = r_prod.cal.ok ?
                          rte_pkg::YEAR_BASE + {5'b0, r_prod.cal.year_off} : 12'd0;
        n_res.month     = r_prod.cal.month;
        n_res.day       = r_prod.cal.day;
        n_res.weekday   = r_prod.cal.weekday;
        n_res.hour      = r_prod.cal.hour;
        n_res.minute    = r_prod.cal.minute;
        n_res.second    = r_prod.cal.second;
        n_res.utc_epoch = r_prod.cal.ok ? r_prod.day_secs + {15'b0, r_prod.sod} : 32'd0;
    end

    // valid bits of both stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_mul <= 1'b0;
            r_valid_out <= 1'b0;
        end else begin
            if (o_ready) begin
                r_valid_mul <= i_valid;
            end
            if (ready_out) begin
                r_valid_out <= r_valid_mul;
            end
        end
    end

    // payload of both stages
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_prod <= n_prod;
        end
        if (ready_out && r_valid_mul) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid_out;
    assign o_res   = r_res;

endmodule

FILE: hw/rtl/rtc_bcd_time_to_epoch_core.sv
`timescale 1ns / 1ps
// top level of the rtc register to epoch converter
// depends on rte_pkg, rte_in_if, rte_out_if, rte_decode, rte_days, rte_epoch

// Converts one set of seven BCD time-keeping register bytes into calendar fields and
// UTC seconds since 1970, one result per register set. The datapath is a four-stage
// pipeline (decode and checks, day count, multiply by 86400, final add into the output
// register); a new register set is taken every cycle while input ready is high, and the
// ready chain runs back from the output register, so input ready drops only while the
// output holds a result that is not being taken. Failed checks give valid_res 0 with all
// other fields 0. The stop-flag check register resets to 1 and should be written only
// while the pipeline is empty.

module rtc_bcd_time_to_epoch_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    rte_in_if.sink     i_in,
    rte_out_if.source  o_out
);

    logic          r_osc_check;
    rte_pkg::t_raw raw;
    rte_pkg::t_dec dec;
    rte_pkg::t_day day_data;
    rte_pkg::t_res res;
    logic          dec_valid, dec_ready;
    logic          day_valid, day_ready;

    // stop-flag check configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_osc_check <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_osc_check <= i_cfg_wr_data;
        end
    end

    // input payload gathered into one word
    always_comb begin
        raw.seconds_code = i_in.seconds_code;
        raw.minutes_code = i_in.minutes_code;
        raw.hours_code   = i_in.hours_code;
        raw.days_code    = i_in.days_code;
        raw.weekday_code = i_in.weekday_code;
        raw.months_code  = i_in.months_code;
        raw.years_code   = i_in.years_code;
    end

    rte_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_osc_check (r_osc_check),
        .i_valid     (i_in.valid),
        .o_ready     (i_in.ready),
        .i_raw       (raw),
        .o_valid     (dec_valid),
        .i_ready     (dec_ready),
        .o_dec       (dec)
    );

    rte_days u_days (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_valid),
        .o_ready (dec_ready),
        .i_dec   (dec),
        .o_valid (day_valid),
        .i_ready (day_ready),
        .o_day   (day_data)
    );

    rte_epoch u_epoch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (day_valid),
        .o_ready (day_ready),
        .i_day   (day_data),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_res   (res)
    );

    // result onto the output channel
    always_comb begin
        o_out.valid_res = res.valid_res;
        o_out.year      = res.year;
        o_out.month     = res.month;
        o_out.day       = res.day;
        o_out.weekday   = res.weekday;
        o_out.hour      = res.hour;
        o_out.minute    = res.minute;
        o_out.second    = res.second;
        o_out.utc_epoch = res.utc_epoch;
    end

    // back-pressure only comes from a stalled output register
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (o_out.valid && !o_out.ready))
        else $error("input stalled without a stalled output");

    // rejected items carry zeros
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.valid_res) |->
            (o_out.utc_epoch == 32'd0 && o_out.year == 12'd0 && o_out.month == 4'd0
             && o_out.day == 5'd0 && o_out.hour == 5'd0))
        else $error("rejected result with non-zero fields");

    // accepted items lie within the calendar range
    a_accept_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.valid_res) |->
            (o_out.year >= 12'd2000 && o_out.year <= 12'd2099 && o_out.month >= 4'd1
             && o_out.month <= 4'd12 && o_out.day >= 5'd1 && o_out.hour <= 5'd23
             && o_out.utc_epoch >= 32'd946684800))
        else $error("valid result out of calendar range");

    // an input transfer leaves the first stage occupied
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> dec_valid)
        else $error("transfer lost at the first stage");

endmodule

FILE: tb/rtc_bcd_time_to_epoch_core_test.sv
`timescale 1ns / 1ps
// self-checking bench for the rtc register set to epoch converter
// depends on rte_pkg, rte_in_if, rte_out_if and rtc_bcd_time_to_epoch_core

module rtc_bcd_time_to_epoch_core_test;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic i_cfg_wr_data;

    rte_in_if  in_ch ();
    rte_out_if out_ch ();

    rtc_bcd_time_to_epoch_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_ch),
        .o_out         (out_ch)
    );

    // expected results in transfer order, and the bench copy of the stop-flag check
    rte_pkg::t_res expected_times[$];
    bit   stop_check_copy;
    int   error_count;

    // idling switches and the long receiver hold-off request
    bit sender_idles;
    bit receiver_stalls;
    bit hold_request;

    // clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // ---------------------------------------------------------------- prediction

    function automatic bit is_leap(input int yr);
        return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    function automatic int days_in_month(input int yr, input int mo);
        int len;
        case (mo)
            2:             len = is_leap(yr) ? 29 : 28;
            4, 6, 9, 11:   len = 30;
            default:       len = 31;
        endcase
        return len;
    endfunction

    function automatic int bcd_to_int(input logic [7:0] b);
        return int'(b[7:4]) * 10 + int'(b[3:0]);
    endfunction

    function automatic logic [7:0] int_to_bcd(input int v);
        logic [7:0] b;
        b[7:4] = 4'(v / 10);
        b[3:0] = 4'(v % 10);
        return b;
    endfunction

    function automatic bit digits_ok(input logic [7:0] b, input int lim);
        return (b[7:4] <= 4'd9) && (b[3:0] <= 4'd9) && (bcd_to_int(b) <= lim);
    endfunction

    // decoded calendar fields and epoch seconds for one register set
    function automatic rte_pkg::t_res predict_time_fields(input rte_pkg::t_raw regs,
                                                          input bit stop_check);
        rte_pkg::t_res res;
        logic [7:0]  sec_b, min_b, hr_b, day_b, mon_b, yr_b;
        logic [2:0]  wd;
        int          yo, yr, mo, dy, hr, mn, sc, m;
        longint      days;
        longint      secs;
        bit          good;
        res   = '0;
        sec_b = regs.seconds_code & rte_pkg::MASK_7;
        min_b = regs.minutes_code & rte_pkg::MASK_7;
        hr_b  = regs.hours_code & rte_pkg::MASK_6;
        day_b = regs.days_code & rte_pkg::MASK_6;
        mon_b = regs.months_code & rte_pkg::MASK_5;
        yr_b  = regs.years_code;
        wd    = regs.weekday_code[2:0];
        good  = !(stop_check && (regs.seconds_code & rte_pkg::OSC_STOP_BIT) != 8'h00);
        good  = good && digits_ok(sec_b, 59) && digits_ok(min_b, 59) && digits_ok(hr_b, 23)
                && digits_ok(day_b, 31) && digits_ok(mon_b, 12) && digits_ok(yr_b, 99);
        yo = bcd_to_int(yr_b);
        yr = 2000 + yo;
        mo = bcd_to_int(mon_b);
        dy = bcd_to_int(day_b);
        hr = bcd_to_int(hr_b);
        mn = bcd_to_int(min_b);
        sc = bcd_to_int(sec_b);
        if (good && (mo < 1 || mo > 12 || dy < 1 || dy > days_in_month(yr, mo) || wd == 3'd7))
            good = 1'b0;
        if (!good)
            return res;
        // whole years from 1970 to 2000, then the years, months and days after
        days = 10957 + yo * 365 + (yo + 3) / 4 + dy - 1;
        for (m = 1; m < mo; m++)
            days += days_in_month(yr, m);
        secs = days * 86400 + hr * 3600 + mn * 60 + sc;
        res.valid_res = 1'b1;
        res.year      = 12'(yr);
        res.month     = 4'(mo);
        res.day       = 5'(dy);
        res.weekday   = wd;
        res.hour      = 5'(hr);
        res.minute    = 6'(mn);
        res.second    = 6'(sc);
        res.utc_epoch = secs[31:0];
        return res;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic rte_pkg::t_raw make_regs(input logic [7:0] sc, input logic [7:0] mn,
                                                input logic [7:0] hr, input logic [7:0] dy,
                                                input logic [7:0] wd, input logic [7:0] mo,
                                                input logic [7:0] yr);
        rte_pkg::t_raw r;
        r.seconds_code = sc;
        r.minutes_code = mn;
        r.hours_code   = hr;
        r.days_code    = dy;
        r.weekday_code = wd;
        r.months_code  = mo;
        r.years_code   = yr;
        return r;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // well-formed register sets with noise in the ignored bits, some broken ones, some junk
    function automatic rte_pkg::t_raw random_regs(input bit stop_check);
        rte_pkg::t_raw r;
        int   pick, yo, mo, dy, len;
        logic [7:0] stop;
        pick = $urandom_range(0, 99);
        yo   = $urandom_range(0, 99);
        mo   = $urandom_range(1, 12);
        len  = days_in_month(2000 + yo, mo);
        dy   = ($urandom_range(0, 3) == 0) ? len : $urandom_range(1, len);
        if (stop_check)
            stop = ($urandom_range(0, 19) == 0) ? rte_pkg::OSC_STOP_BIT : 8'h00;
        else
            stop = ($urandom_range(0, 1) == 1) ? rte_pkg::OSC_STOP_BIT : 8'h00;
        r = make_regs(stop | int_to_bcd($urandom_range(0, 59)),
                      (8'($urandom_range(0, 1)) << 7) | int_to_bcd($urandom_range(0, 59)),
                      (8'($urandom_range(0, 3)) << 6) | int_to_bcd($urandom_range(0, 23)),
                      (8'($urandom_range(0, 3)) << 6) | int_to_bcd(dy),
                      (8'($urandom_range(0, 31)) << 3) | 8'($urandom_range(0, 6)),
                      (8'($urandom_range(0, 7)) << 5) | int_to_bcd(mo),
                      int_to_bcd(yo));
        if (pick < 70)
            return r;
        if (pick < 88) begin
            // break one field
            case ($urandom_range(0, 8))
                0: r.seconds_code = 8'($urandom_range(0, 255));
                1: r.minutes_code = 8'($urandom_range(0, 255));
                2: r.hours_code   = 8'($urandom_range(0, 255));
                3: r.days_code    = 8'($urandom_range(0, 255));
                4: r.weekday_code = r.weekday_code | rte_pkg::MASK_3;
                5: r.months_code  = 8'($urandom_range(0, 255));
                6: r.years_code   = 8'($urandom_range(0, 255));
                7: begin
                    // day past the end of a short month
                    case ($urandom_range(0, 4))
                        0:       mo = 2;
                        1:       mo = 4;
                        2:       mo = 6;
                        3:       mo = 9;
                        default: mo = 11;
                    endcase
                    len = days_in_month(2000 + yo, mo);
                    r.months_code = int_to_bcd(mo);
                    r.days_code   = int_to_bcd($urandom_range(len + 1, 31));
                end
                default: r.days_code = r.days_code & 8'hC0;
            endcase
            return r;
        end
        return make_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
    endfunction

    // ---------------------------------------------------------------- driving

    // offer one register set and wait for its transfer
    task automatic send_regs(input rte_pkg::t_raw regs);
        int gap;
        gap = 0;
        if (sender_idles && $urandom_range(0, 2) == 0)
            gap = gap_length();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.seconds_code <= regs.seconds_code;
        in_ch.minutes_code <= regs.minutes_code;
        in_ch.hours_code   <= regs.hours_code;
        in_ch.days_code    <= regs.days_code;
        in_ch.weekday_code <= regs.weekday_code;
        in_ch.months_code  <= regs.months_code;
        in_ch.years_code   <= regs.years_code;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        expected_times.push_back(predict_time_fields(regs, stop_check_copy));
    endtask

    // stop offering and let every result come out
    task automatic drain_pipeline();
        in_ch.valid <= 1'b0;
        while (expected_times.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // stop-flag check is written only with the pipeline empty
    task automatic write_stop_check(input bit value);
        drain_pipeline();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en     <= 1'b0;
        stop_check_copy = value;
    endtask

    // receiver ready: random stalls, and a long hold-off when one is requested
    initial begin
        int stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = 200;
                out_ch.ready <= 1'b0;
            end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
                stall_left   = gap_length() - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- checking

    always @(posedge i_clk) begin
        rte_pkg::t_res got;
        rte_pkg::t_res want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.valid_res = out_ch.valid_res;
            got.year      = out_ch.year;
            got.month     = out_ch.month;
            got.day       = out_ch.day;
            got.weekday   = out_ch.weekday;
            got.hour      = out_ch.hour;
            got.minute    = out_ch.minute;
            got.second    = out_ch.second;
            got.utc_epoch = out_ch.utc_epoch;
            if (expected_times.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result transfer: valid_res %0d epoch %0d",
                             got.valid_res, got.utc_epoch);
            end else begin
                want = expected_times.pop_front();
                if (got.valid_res !== want.valid_res || got.year !== want.year
                    || got.month !== want.month || got.day !== want.day
                    || got.weekday !== want.weekday || got.hour !== want.hour
                    || got.minute !== want.minute || got.second !== want.second
                    || got.utc_epoch !== want.utc_epoch) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("expected: v%0d %0d-%0d-%0d wd%0d %0d:%0d:%0d epoch %0d",
                                 want.valid_res, want.year, want.month, want.day,
                                 want.weekday, want.hour, want.minute, want.second,
                                 want.utc_epoch);
                        $display("actual:   v%0d %0d-%0d-%0d wd%0d %0d:%0d:%0d epoch %0d",
                                 got.valid_res, got.year, got.month, got.day,
                                 got.weekday, got.hour, got.minute, got.second,
                                 got.utc_epoch);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // field extremes, leap days, month ends, bad digits and ignored bits
    task automatic test_directed_fields();
        send_regs(make_regs(8'h00, 8'h00, 8'h00, 8'h01, 8'h06, 8'h01, 8'h00));
        send_regs(make_regs(8'h59, 8'h59, 8'h23, 8'h31, 8'h03, 8'h12, 8'h99));
        send_regs(make_regs(8'h80, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00));
        send_regs(make_regs(8'h30, 8'h15, 8'h12, 8'h29, 8'h02, 8'h02, 8'h00));
        send_regs(make_regs(8'h30, 8'h15, 8'h12, 8'h29, 8'h02, 8'h02, 8'h01));
        send_regs(make_regs(8'h30, 8'h15, 8'h12, 8'h28, 8'h02, 8'h02, 8'h01));
        send_regs(make_regs(8'h00, 8'h00, 8'h00, 8'h31, 8'h04, 8'h04, 8'h24));
        send_regs(make_regs(8'h00, 8'h00, 8'h00, 8'h30, 8'h04, 8'h04, 8'h24));
        send_regs(make_regs(8'h5A, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'h10));
        send_regs(make_regs(8'h00, 8'h3C, 8'h00, 8'h01, 8'h00, 8'h01, 8'h10));
        send_regs(make_regs(8'h00, 8'h00, 8'h24, 8'h01, 8'h00, 8'h01, 8'h10));
        send_regs(make_regs(8'h00, 8'h00, 8'h1A, 8'h01, 8'h00, 8'h01, 8'h10));
        send_regs(make_regs(8'h00, 8'h00, 8'h00, 8'h32, 8'h00, 8'h01, 8'h10));
        send_regs(make_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h10));
        send_regs(make_regs(8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h13, 8'h10));
        send_regs(make_regs(8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h10));
        send_regs(make_regs(8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h0A, 8'h10));
        send_regs(make_regs(8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'h9A));
        send_regs(make_regs(8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'hA0));
        send_regs(make_regs(8'h00, 8'h00, 8'h00, 8'h01, 8'h07, 8'h01, 8'h10));
        send_regs(make_regs(8'h45, 8'hD9, 8'hE3, 8'hD5, 8'hFD, 8'hF2, 8'h48));
        send_regs(make_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_regs(make_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    endtask

    // with the check off the stop flag is dropped, with it on the read is rejected
    task automatic test_stop_flag_config();
        write_stop_check(1'b0);
        send_regs(make_regs(8'hD9, 8'h59, 8'h23, 8'h31, 8'h06, 8'h12, 8'h99));
        send_regs(make_regs(8'h80, 8'h00, 8'h00, 8'h01, 8'h06, 8'h01, 8'h00));
        send_regs(make_regs(8'h25, 8'h00, 8'h00, 8'h01, 8'h06, 8'h01, 8'h00));
        send_regs(make_regs(8'hDA, 8'h00, 8'h00, 8'h01, 8'h06, 8'h01, 8'h00));
        write_stop_check(1'b1);
        send_regs(make_regs(8'hD9, 8'h59, 8'h23, 8'h31, 8'h06, 8'h12, 8'h99));
    endtask

    // back-to-back transfers with no idling on either side
    task automatic test_random_streaming();
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
        repeat (300) send_regs(random_regs(stop_check_copy));
    endtask

    // random gaps and stalls on both sides
    task automatic test_random_with_gaps();
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
        repeat (450) send_regs(random_regs(stop_check_copy));
    endtask

    // receiver holds off while the sender keeps offering, filling the pipeline
    task automatic test_output_backpressure();
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
        hold_request    = 1'b1;
        repeat (60) send_regs(random_regs(stop_check_copy));
    endtask

    // random traffic with the stop-flag check off
    task automatic test_random_check_off();
        write_stop_check(1'b0);
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
        repeat (200) send_regs(random_regs(stop_check_copy));
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        error_count     = 0;
        stop_check_copy = 1'b1;
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
        hold_request    = 1'b0;
        i_rst_n            <= 1'b0;
        i_cfg_wr_en        <= 1'b0;
        i_cfg_wr_data      <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.seconds_code <= 8'h00;
        in_ch.minutes_code <= 8'h00;
        in_ch.hours_code   <= 8'h00;
        in_ch.days_code    <= 8'h00;
        in_ch.weekday_code <= 8'h00;
        in_ch.months_code  <= 8'h00;
        in_ch.years_code   <= 8'h00;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_stop_check(1'b1);
        test_directed_fields();
        test_stop_flag_config();
        test_random_streaming();
        test_random_with_gaps();
        test_output_backpressure();
        test_random_check_off();
        drain_pipeline();

        if (error_count == 0)
            $display("rtc_bcd_time_to_epoch_core test passed");
        else
            $display("rtc_bcd_time_to_epoch_core test failed");
        $finish;
    end

    // run limit
    initial begin
        #5000000;
        $display("rtc_bcd_time_to_epoch_core test failed");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/rte_pkg.sv
hw/rtl/rte_in_if.sv
hw/rtl/rte_out_if.sv
hw/rtl/rte_decode.sv
hw/rtl/rte_days.sv
hw/rtl/rte_epoch.sv
hw/rtl/rtc_bcd_time_to_epoch_core.sv
tb/rtc_bcd_time_to_epoch_core_test.sv
